/* hw/rtl/jpsi_pkg.sv */
// jpsi_pkg: shared types, constants and target pose tables of the
// joint pose sequence interpolator; no dependencies
package jpsi_pkg;

    localparam int NUM_JOINTS_DEF = 12;
    localparam int POSE_JOINTS    = 12;
    localparam int FRAC_W         = 17;
    localparam int POS_W          = 16;
    localparam int GAIN_W         = 16;
    localparam int CNT_W          = 16;
    localparam int JOINT_W        = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;
    localparam int NUM_PHASES     = 4;
    localparam int PROD_W         = 35;
    localparam int SUM_W          = 36;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE1_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE2_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE3_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE4_STEP = 3'd6;

    localparam logic [GAIN_W-1:0] P_GAIN_RST      = 16'd15360;
    localparam logic [GAIN_W-1:0] D_GAIN_RST      = 16'd1280;
    localparam logic [CNT_W-1:0]  START_DELAY_RST = 16'd500;
    localparam logic [FRAC_W-1:0] STEP_RST        = 17'd131;

    localparam logic signed [POS_W-1:0] POSE1 [POSE_JOINTS] = '{
        16'sd0, 16'sd5571, -16'sd10854, 16'sd0, 16'sd5571, -16'sd10854,
        -16'sd819, 16'sd5571, -16'sd10854, 16'sd819, 16'sd5571, -16'sd10854};
    localparam logic signed [POS_W-1:0] POSE2 [POSE_JOINTS] = '{
        16'sd0, 16'sd2744, -16'sd5325, 16'sd0, 16'sd2744, -16'sd5325,
        16'sd0, 16'sd2744, -16'sd5325, 16'sd0, 16'sd2744, -16'sd5325};
    localparam logic signed [POS_W-1:0] POSE3 [POSE_JOINTS] = '{
        16'sd23, 16'sd2248, -16'sd7855, -16'sd23, 16'sd2248, -16'sd7855,
        16'sd23, 16'sd1674, -16'sd4168, -16'sd23, 16'sd1674, -16'sd4168};
    localparam logic signed [POS_W-1:0] POSE4 [POSE_JOINTS] = '{
        16'sd23, 16'sd2658, -16'sd8986, -16'sd23, 16'sd2658, -16'sd8986,
        16'sd23, 16'sd2084, -16'sd5094, -16'sd23, 16'sd2084, -16'sd5094};

    typedef struct packed {
        logic [GAIN_W-1:0]                  p_gain;
        logic [GAIN_W-1:0]                  d_gain;
        logic [CNT_W-1:0]                   start_delay;
        logic [NUM_PHASES-1:0][FRAC_W-1:0]  step;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic sample;
        logic tick;
        logic advance;
        logic load;
        logic mul;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic tick_active;
        logic out_free;
    } t_dp_status;

    // target pose by index (0 = pose1 .. 3 = pose4); joints past the table read zero
    function automatic logic signed [POS_W-1:0] target_pos(
        input logic [1:0] pose_sel,
        input logic [4:0] joint
    );
        logic signed [POS_W-1:0] v;
        v = '0;
        if (joint < 5'(POSE_JOINTS)) begin
            case (pose_sel)
                2'd0:    v = POSE1[joint[3:0]];
                2'd1:    v = POSE2[joint[3:0]];
                2'd2:    v = POSE3[joint[3:0]];
                default: v = POSE4[joint[3:0]];
            endcase
        end
        return v;
    endfunction

endpackage

/* hw/rtl/jpsi_ctrl.sv */
// jpsi_ctrl: sequencing state machine, walks the joints of an active tick
// depends on jpsi_pkg
module jpsi_ctrl #(
    parameter int NUM_JOINTS = jpsi_pkg::NUM_JOINTS_DEF,
    parameter int JW         = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_op,
    output logic                 o_in_stall,
    input  jpsi_pkg::t_dp_status i_status,
    output jpsi_pkg::t_dp_cmd    o_cmd,
    output logic [JW-1:0]        o_joint
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADV  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [JW-1:0] LAST_JOINT = JW'(NUM_JOINTS - 1);

    logic [2:0]    r_state, n_state;
    logic [JW-1:0] r_joint, n_joint;
    logic          in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_joint    = r_joint;

    always_comb begin
        n_state = r_state;
        n_joint = r_joint;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_op) begin
                        o_cmd.sample = 1'b1;
                    end else begin
                        o_cmd.tick = 1'b1;
                        if (i_status.tick_active) begin
                            n_state = S_ADV;
                        end
                    end
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_joint       = '0;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_joint == LAST_JOINT) begin
                        n_state = S_IDLE;
                    end else begin
                        n_joint = r_joint + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_joint <= '0;
        end else begin
            r_state <= n_state;
            r_joint <= n_joint;
        end
    end

endmodule

/* hw/rtl/jpsi_datapath.sv */
// jpsi_datapath: measured table, start pose, delay counter, phase fractions,
// shared interpolation multiplier and output register; depends on jpsi_pkg
module jpsi_datapath #(
    parameter int NUM_JOINTS = jpsi_pkg::NUM_JOINTS_DEF,
    parameter int JW         = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  jpsi_pkg::t_cfg                         i_cfg,
    input  jpsi_pkg::t_dp_cmd                      i_cmd,
    input  logic [JW-1:0]                          i_joint,
    output jpsi_pkg::t_dp_status                   o_status,
    input  logic [jpsi_pkg::JOINT_W-1:0]           i_joint_index,
    input  logic signed [jpsi_pkg::POS_W-1:0]      i_measured_pos,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [jpsi_pkg::JOINT_W-1:0]           o_cmd_joint,
    output logic signed [jpsi_pkg::POS_W-1:0]      o_cmd_pos,
    output logic [jpsi_pkg::GAIN_W-1:0]            o_cmd_p_gain,
    output logic [jpsi_pkg::GAIN_W-1:0]            o_cmd_d_gain,
    output logic                                   o_last_joint
);

    localparam int FW = jpsi_pkg::FRAC_W;
    localparam int PW = jpsi_pkg::POS_W;
    localparam logic [FW-1:0] ONE = jpsi_pkg::FRAC_ONE;

    logic signed [PW-1:0] r_meas  [NUM_JOINTS];
    logic signed [PW-1:0] r_start [NUM_JOINTS];
    logic [jpsi_pkg::CNT_W-1:0] r_cnt;
    logic [jpsi_pkg::CNT_W-1:0] cnt_inc;
    logic r_latched;
    logic [jpsi_pkg::NUM_PHASES-1:0][FW-1:0] r_frac, n_frac;
    logic [1:0] r_phase, n_phase;

    logic signed [PW-1:0]   r_a;
    logic signed [FW-1:0]   r_diff;
    logic [FW-1:0]          r_f;
    logic signed [jpsi_pkg::PROD_W-1:0] r_prod;

    logic                   r_out_valid;
    logic [jpsi_pkg::JOINT_W-1:0] r_cmd_joint;
    logic signed [PW-1:0]   r_cmd_pos;
    logic [jpsi_pkg::GAIN_W-1:0] r_cmd_p_gain, r_cmd_d_gain;
    logic                   r_last;

    logic [4:0]             idx5, joint5;
    logic signed [PW-1:0]   op_a, op_b;
    logic signed [jpsi_pkg::SUM_W-1:0] sum;
    logic signed [jpsi_pkg::SUM_W-1:0] shifted;

    function automatic logic [FW-1:0] advance(input logic [FW-1:0] f, input logic [FW-1:0] s);
        logic [FW:0] n;
        n = {1'b0, f} + {1'b0, s};
        return (n > {1'b0, ONE}) ? ONE : n[FW-1:0];
    endfunction

    assign idx5   = 5'(i_joint_index);
    assign joint5 = 5'(i_joint);

    // saturating delay count as it will be after this tick
    assign cnt_inc = (r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
    assign o_status.tick_active = (cnt_inc >= i_cfg.start_delay);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    // phase cascade: a finished phase hands the tick to the next one
    always_comb begin
        n_frac    = r_frac;
        n_frac[0] = advance(r_frac[0], i_cfg.step[0]);
        n_phase   = 2'd0;
        if (n_frac[0] == ONE && r_frac[1] < ONE) begin
            n_frac[1] = advance(r_frac[1], i_cfg.step[1]);
            n_phase   = 2'd1;
        end
        if (n_frac[0] == ONE && n_frac[1] == ONE && r_frac[2] < ONE) begin
            n_frac[2] = advance(r_frac[2], i_cfg.step[2]);
            n_phase   = 2'd2;
        end
        if (n_frac[0] == ONE && n_frac[1] == ONE && n_frac[2] == ONE) begin
            n_frac[3] = advance(r_frac[3], i_cfg.step[3]);
            n_phase   = 2'd3;
        end
    end

    // interpolation end points of the current joint
    always_comb begin
        op_b = jpsi_pkg::target_pos(r_phase, joint5);
        case (r_phase)
            2'd0:    op_a = r_start[i_joint];
            2'd1:    op_a = jpsi_pkg::target_pos(2'd0, joint5);
            2'd2:    op_a = jpsi_pkg::target_pos(2'd1, joint5);
            default: op_a = jpsi_pkg::target_pos(2'd2, joint5);
        endcase
    end

    // a*65536 + f*(b-a) + half, floor shift
    assign sum = {{(jpsi_pkg::SUM_W-PW-16){r_a[PW-1]}}, r_a, 16'h0000}
               + jpsi_pkg::SUM_W'(r_prod) + jpsi_pkg::SUM_W'(32768);
    assign shifted = sum >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_meas[k] <= '0;
            end
            r_cnt       <= '0;
            r_latched   <= 1'b0;
            r_frac      <= '0;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sample && (32'(i_joint_index) < NUM_JOINTS)) begin
                r_meas[idx5[JW-1:0]] <= i_measured_pos;
            end
            if (i_cmd.tick) begin
                r_cnt <= cnt_inc;
                if (o_status.tick_active && !r_latched) begin
                    r_latched <= 1'b1;
                end
            end
            if (i_cmd.advance) begin
                r_frac  <= n_frac;
                r_phase <= n_phase;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && o_status.tick_active && !r_latched) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_start[k] <= r_meas[k];
            end
        end
        if (i_cmd.load) begin
            r_a    <= op_a;
            r_diff <= FW'(op_b) - FW'(op_a);
            r_f    <= r_frac[r_phase];
        end
        if (i_cmd.mul) begin
            r_prod <= jpsi_pkg::PROD_W'(r_diff) * jpsi_pkg::PROD_W'($signed({1'b0, r_f}));
        end
        if (i_cmd.emit) begin
            r_cmd_joint  <= joint5[jpsi_pkg::JOINT_W-1:0];
            r_cmd_pos    <= shifted[PW-1:0];
            r_cmd_p_gain <= i_cfg.p_gain;
            r_cmd_d_gain <= i_cfg.d_gain;
            r_last       <= (32'(i_joint) == NUM_JOINTS - 1);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cmd_joint  = r_cmd_joint;
    assign o_cmd_pos    = r_cmd_pos;
    assign o_cmd_p_gain = r_cmd_p_gain;
    assign o_cmd_d_gain = r_cmd_d_gain;
    assign o_last_joint = r_last;

endmodule

/* hw/rtl/joint_pose_sequence_interpolator.sv */
// joint_pose_sequence_interpolator: top level, configuration registers,
// controller and datapath; depends on jpsi_pkg, jpsi_ctrl, jpsi_datapath
//
// Input channel (i_in_valid / o_in_stall) carries samples (i_op = 0), which
// store a measured joint position, and control ticks (i_op = 1). A beat is
// taken when valid is high and stall is low. A sample never raises o_in_stall.
// A tick advances the start delay counter; once the delay has passed it
// latches the start pose (first time only), steps the four phase fractions
// in turn, a finished phase handing on to the next, and sends NUM_JOINTS
// commands on the output channel (o_out_valid / i_out_stall), the last one
// flagged by o_last_joint. Each command goes through one shared 17x18
// multiplier in order: operand select, multiply, round into the output
// register. o_in_stall stays high until the last command has entered the
// output register. A stall on the output holds the command and pauses the
// sequence. Configuration writes (i_cfg_valid, o_cfg_ready always high) are
// taken at any time and are meant for idle periods.
// Reset clears the measured table, delay counter, fractions and restores
// register defaults.
module joint_pose_sequence_interpolator #(
    parameter int NUM_JOINTS = jpsi_pkg::NUM_JOINTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_op,
    input  logic [jpsi_pkg::JOINT_W-1:0]           i_joint_index,
    input  logic signed [jpsi_pkg::POS_W-1:0]      i_measured_pos,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [jpsi_pkg::JOINT_W-1:0]           o_cmd_joint,
    output logic signed [jpsi_pkg::POS_W-1:0]      o_cmd_pos,
    output logic [jpsi_pkg::GAIN_W-1:0]            o_cmd_p_gain,
    output logic [jpsi_pkg::GAIN_W-1:0]            o_cmd_d_gain,
    output logic                                   o_last_joint,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [jpsi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [jpsi_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    jpsi_pkg::t_cfg       r_cfg;
    jpsi_pkg::t_dp_cmd    cmd;
    jpsi_pkg::t_dp_status status;
    logic [JW-1:0]        joint;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain      <= jpsi_pkg::P_GAIN_RST;
            r_cfg.d_gain      <= jpsi_pkg::D_GAIN_RST;
            r_cfg.start_delay <= jpsi_pkg::START_DELAY_RST;
            for (int k = 0; k < jpsi_pkg::NUM_PHASES; k++) begin
                r_cfg.step[k] <= jpsi_pkg::STEP_RST;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jpsi_pkg::CFG_P_GAIN:      r_cfg.p_gain      <= i_cfg_data[15:0];
                jpsi_pkg::CFG_D_GAIN:      r_cfg.d_gain      <= i_cfg_data[15:0];
                jpsi_pkg::CFG_START_DELAY: r_cfg.start_delay <= i_cfg_data[15:0];
                jpsi_pkg::CFG_PHASE1_STEP: r_cfg.step[0]     <= i_cfg_data;
                jpsi_pkg::CFG_PHASE2_STEP: r_cfg.step[1]     <= i_cfg_data;
                jpsi_pkg::CFG_PHASE3_STEP: r_cfg.step[2]     <= i_cfg_data;
                jpsi_pkg::CFG_PHASE4_STEP: r_cfg.step[3]     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    jpsi_ctrl #(
        .NUM_JOINTS (NUM_JOINTS),
        .JW         (JW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_joint    (joint)
    );

    jpsi_datapath #(
        .NUM_JOINTS (NUM_JOINTS),
        .JW         (JW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (cmd),
        .i_joint        (joint),
        .o_status       (status),
        .i_joint_index  (i_joint_index),
        .i_measured_pos (i_measured_pos),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cmd_joint    (o_cmd_joint),
        .o_cmd_pos      (o_cmd_pos),
        .o_cmd_p_gain   (o_cmd_p_gain),
        .o_cmd_d_gain   (o_cmd_d_gain),
        .o_last_joint   (o_last_joint)
    );

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for joint_pose_sequence_interpolator; tracks the
// measured table, delay counter and phase fractions to predict every joint command
// depends on jpsi_pkg and the rtl only
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NJ           = jpsi_pkg::NUM_JOINTS_DEF;
    localparam int  DRAIN_CYCLES = 48;
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        SEG_TO_POSE1,
        SEG_TO_POSE2,
        SEG_TO_POSE3,
        SEG_TO_POSE4
    } t_seg;

    typedef struct {
        logic [jpsi_pkg::JOINT_W-1:0]      joint;
        logic signed [jpsi_pkg::POS_W-1:0] pos;
        logic [jpsi_pkg::GAIN_W-1:0]       p_gain;
        logic [jpsi_pkg::GAIN_W-1:0]       d_gain;
        logic                              last;
    } t_joint_cmd;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic                                i_op;
    logic [jpsi_pkg::JOINT_W-1:0]        i_joint_index;
    logic signed [jpsi_pkg::POS_W-1:0]   i_measured_pos;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [jpsi_pkg::JOINT_W-1:0]        o_cmd_joint;
    logic signed [jpsi_pkg::POS_W-1:0]   o_cmd_pos;
    logic [jpsi_pkg::GAIN_W-1:0]         o_cmd_p_gain;
    logic [jpsi_pkg::GAIN_W-1:0]         o_cmd_d_gain;
    logic                                o_last_joint;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [jpsi_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [jpsi_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    // shadow of the block state
    logic signed [jpsi_pkg::POS_W-1:0]   meas_tab [NJ];
    logic signed [jpsi_pkg::POS_W-1:0]   start_pose [NJ];
    logic [jpsi_pkg::CNT_W-1:0]          ticks_seen;
    bit                                  latched;
    logic [jpsi_pkg::FRAC_W-1:0]         frac [jpsi_pkg::NUM_PHASES];
    logic [jpsi_pkg::GAIN_W-1:0]         cur_p_gain;
    logic [jpsi_pkg::GAIN_W-1:0]         cur_d_gain;
    logic [jpsi_pkg::CNT_W-1:0]          cur_delay;
    logic [jpsi_pkg::FRAC_W-1:0]         cur_step [jpsi_pkg::NUM_PHASES];

    t_joint_cmd                          pending_cmds [$];
    int                                  mismatches;
    bit                                  idle_on = 1'b1;

    joint_pose_sequence_interpolator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_joint_index  (i_joint_index),
        .i_measured_pos (i_measured_pos),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cmd_joint    (o_cmd_joint),
        .o_cmd_pos      (o_cmd_pos),
        .o_cmd_p_gain   (o_cmd_p_gain),
        .o_cmd_d_gain   (o_cmd_d_gain),
        .o_last_joint   (o_last_joint),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    // random output stall bursts while idle_on is set
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
        end
    end

    // (1-f)*a + f*b in Q1.16, rounded half up
    function automatic logic signed [jpsi_pkg::POS_W-1:0] blend(
        input logic signed [jpsi_pkg::POS_W-1:0] a,
        input logic signed [jpsi_pkg::POS_W-1:0] b,
        input logic [jpsi_pkg::FRAC_W-1:0]       f
    );
        longint acc;
        acc = longint'(65536 - int'(f)) * longint'(a) + longint'(f) * longint'(b) + 32768;
        return jpsi_pkg::POS_W'(acc >>> 16);
    endfunction

    function automatic logic [jpsi_pkg::FRAC_W-1:0] frac_step(
        input logic [jpsi_pkg::FRAC_W-1:0] f,
        input logic [jpsi_pkg::FRAC_W-1:0] s
    );
        int n;
        n = int'(f) + int'(s);
        return (n > int'(jpsi_pkg::FRAC_ONE)) ? jpsi_pkg::FRAC_ONE : jpsi_pkg::FRAC_W'(n);
    endfunction

    function automatic void predict_commands(
        input logic                              op,
        input logic [jpsi_pkg::JOINT_W-1:0]      jidx,
        input logic signed [jpsi_pkg::POS_W-1:0] mpos
    );
        t_seg       seg;
        t_joint_cmd c;
        if (op == OP_SAMPLE) begin
            if (jidx < jpsi_pkg::JOINT_W'(NJ))
                meas_tab[jidx] = mpos;
            return;
        end
        if (ticks_seen != '1)
            ticks_seen++;
        if (ticks_seen < cur_delay)
            return;
        if (!latched) begin
            start_pose = meas_tab;
            latched = 1'b1;
        end
        // a phase reaching one hands off to the next within the same tick
        seg = SEG_TO_POSE4;
        frac[0] = frac_step(frac[0], cur_step[0]);
        if (frac[0] < jpsi_pkg::FRAC_ONE)
            seg = SEG_TO_POSE1;
        if (frac[0] == jpsi_pkg::FRAC_ONE && frac[1] < jpsi_pkg::FRAC_ONE) begin
            frac[1] = frac_step(frac[1], cur_step[1]);
            seg = SEG_TO_POSE2;
        end
        if (frac[0] == jpsi_pkg::FRAC_ONE && frac[1] == jpsi_pkg::FRAC_ONE
                && frac[2] < jpsi_pkg::FRAC_ONE) begin
            frac[2] = frac_step(frac[2], cur_step[2]);
            seg = SEG_TO_POSE3;
        end
        if (frac[0] == jpsi_pkg::FRAC_ONE && frac[1] == jpsi_pkg::FRAC_ONE
                && frac[2] == jpsi_pkg::FRAC_ONE) begin
            frac[3] = frac_step(frac[3], cur_step[3]);
            seg = SEG_TO_POSE4;
        end
        for (int j = 0; j < NJ; j++) begin
            case (seg)
                SEG_TO_POSE1: c.pos = blend(start_pose[j], jpsi_pkg::POSE1[j], frac[0]);
                SEG_TO_POSE2: c.pos = blend(jpsi_pkg::POSE1[j], jpsi_pkg::POSE2[j], frac[1]);
                SEG_TO_POSE3: c.pos = blend(jpsi_pkg::POSE2[j], jpsi_pkg::POSE3[j], frac[2]);
                default:      c.pos = blend(jpsi_pkg::POSE3[j], jpsi_pkg::POSE4[j], frac[3]);
            endcase
            c.joint  = jpsi_pkg::JOINT_W'(j);
            c.p_gain = cur_p_gain;
            c.d_gain = cur_d_gain;
            c.last   = (j == NJ - 1);
            pending_cmds.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin : check_cmds
        t_joint_cmd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected command beat: joint %0d pos %0d", o_cmd_joint, o_cmd_pos);
                mismatches++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_cmd_joint !== want.joint) begin
                    $error("cmd_joint: expected %0d, got %0d", want.joint, o_cmd_joint);
                    mismatches++;
                end
                if (o_cmd_pos !== want.pos) begin
                    $error("cmd_pos: expected %0d, got %0d", want.pos, o_cmd_pos);
                    mismatches++;
                end
                if (o_cmd_p_gain !== want.p_gain) begin
                    $error("cmd_p_gain: expected %0d, got %0d", want.p_gain, o_cmd_p_gain);
                    mismatches++;
                end
                if (o_cmd_d_gain !== want.d_gain) begin
                    $error("cmd_d_gain: expected %0d, got %0d", want.d_gain, o_cmd_d_gain);
                    mismatches++;
                end
                if (o_last_joint !== want.last) begin
                    $error("last_joint: expected %0d, got %0d", want.last, o_last_joint);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_beat(
        input logic                              op,
        input logic [jpsi_pkg::JOINT_W-1:0]      jidx,
        input logic signed [jpsi_pkg::POS_W-1:0] mpos
    );
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_op           = op;
        i_joint_index  = jidx;
        i_measured_pos = mpos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_commands(op, jidx, mpos);
    endtask

    // sample fields ride along with random content and must be ignored
    task automatic send_tick();
        send_beat(OP_TICK, jpsi_pkg::JOINT_W'($urandom), jpsi_pkg::POS_W'($urandom));
    endtask

    // hold off the input until every pending command has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [jpsi_pkg::CFG_IDX_W-1:0]  idx,
        input logic [jpsi_pkg::CFG_DATA_W-1:0] val
    );
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            jpsi_pkg::CFG_P_GAIN:      cur_p_gain  = val[jpsi_pkg::GAIN_W-1:0];
            jpsi_pkg::CFG_D_GAIN:      cur_d_gain  = val[jpsi_pkg::GAIN_W-1:0];
            jpsi_pkg::CFG_START_DELAY: cur_delay   = val[jpsi_pkg::CNT_W-1:0];
            jpsi_pkg::CFG_PHASE1_STEP: cur_step[0] = val[jpsi_pkg::FRAC_W-1:0];
            jpsi_pkg::CFG_PHASE2_STEP: cur_step[1] = val[jpsi_pkg::FRAC_W-1:0];
            jpsi_pkg::CFG_PHASE3_STEP: cur_step[2] = val[jpsi_pkg::FRAC_W-1:0];
            jpsi_pkg::CFG_PHASE4_STEP: cur_step[3] = val[jpsi_pkg::FRAC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [jpsi_pkg::FRAC_W-1:0] pick_step();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return jpsi_pkg::FRAC_ONE;
            2:       return jpsi_pkg::FRAC_W'($urandom_range(65537, 131071));
            3, 4, 5: return jpsi_pkg::FRAC_W'($urandom_range(1, 64));
            default: return jpsi_pkg::FRAC_W'($urandom_range(200, 3000));
        endcase
    endfunction

    function automatic logic [jpsi_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return jpsi_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    // reset gains and steps, silent ticks, first latch of the measured table
    task automatic test_reset_defaults();
        send_beat(OP_SAMPLE, 4'd0, 16'h7FFF);
        send_beat(OP_SAMPLE, 4'd1, 16'h8000);
        send_beat(OP_SAMPLE, 4'd11, jpsi_pkg::POS_W'($urandom));
        send_beat(OP_SAMPLE, 4'd12, jpsi_pkg::POS_W'($urandom));
        send_beat(OP_SAMPLE, 4'd15, jpsi_pkg::POS_W'($urandom));
        repeat (3) send_tick();
        drain_results();
        write_reg(jpsi_pkg::CFG_START_DELAY, 17'd5);
        repeat (3) send_tick();
        // start pose is already latched, this sample must not move it
        send_beat(OP_SAMPLE, 4'd2, jpsi_pkg::POS_W'($urandom));
        send_tick();
    endtask

    task automatic test_delay_edges();
        drain_results();
        write_reg(jpsi_pkg::CFG_START_DELAY, '0);
        send_tick();
        drain_results();
        // raising the delay silences ticks until the counter catches up
        write_reg(jpsi_pkg::CFG_START_DELAY, jpsi_pkg::CFG_DATA_W'(ticks_seen + 16'd2));
        repeat (2) send_tick();
        drain_results();
        write_reg(jpsi_pkg::CFG_START_DELAY, 17'hFFFF);
        send_tick();
        drain_results();
        write_reg(jpsi_pkg::CFG_START_DELAY, '0);
    endtask

    task automatic test_step_extremes();
        drain_results();
        write_reg(jpsi_pkg::CFG_P_GAIN, '0);
        write_reg(jpsi_pkg::CFG_D_GAIN, 17'hFFFF);
        write_reg(jpsi_pkg::CFG_PHASE1_STEP, '0);
        repeat (2) send_tick();
        drain_results();
        // step above one clamps and hands off to phase two in the same tick
        write_reg(jpsi_pkg::CFG_PHASE1_STEP, 17'h1FFFF);
        send_tick();
        drain_results();
        write_reg(jpsi_pkg::CFG_P_GAIN, 17'hFFFF);
        write_reg(jpsi_pkg::CFG_D_GAIN, '0);
        write_reg(jpsi_pkg::CFG_PHASE2_STEP, 17'd1);
        send_tick();
    endtask

    task automatic test_random_sequence();
        logic [jpsi_pkg::CNT_W-1:0] dly;
        for (int round_idx = 0; round_idx < 11; round_idx++) begin
            drain_results();
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       dly = jpsi_pkg::CNT_W'($urandom);
                1, 2:    dly = ticks_seen + jpsi_pkg::CNT_W'($urandom_range(1, 4));
                default: dly = jpsi_pkg::CNT_W'($urandom_range(0, ticks_seen));
            endcase
            write_reg(jpsi_pkg::CFG_START_DELAY, jpsi_pkg::CFG_DATA_W'(dly));
            write_reg(jpsi_pkg::CFG_P_GAIN, jpsi_pkg::CFG_DATA_W'(pick_gain()));
            write_reg(jpsi_pkg::CFG_D_GAIN, jpsi_pkg::CFG_DATA_W'(pick_gain()));
            write_reg(jpsi_pkg::CFG_PHASE1_STEP, pick_step());
            write_reg(jpsi_pkg::CFG_PHASE2_STEP, pick_step());
            write_reg(jpsi_pkg::CFG_PHASE3_STEP, pick_step());
            write_reg(jpsi_pkg::CFG_PHASE4_STEP, pick_step());
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(0, 9) < 4)
                    send_beat(OP_SAMPLE, jpsi_pkg::JOINT_W'($urandom),
                              jpsi_pkg::POS_W'($urandom));
                else
                    send_tick();
            end
        end
    endtask

    // all steps at one: remaining phases complete in one tick, then pose4 holds
    task automatic test_finish_and_hold();
        drain_results();
        idle_on = 1'b0;
        write_reg(jpsi_pkg::CFG_START_DELAY, '0);
        write_reg(jpsi_pkg::CFG_PHASE1_STEP, jpsi_pkg::FRAC_ONE);
        write_reg(jpsi_pkg::CFG_PHASE2_STEP, jpsi_pkg::FRAC_ONE);
        write_reg(jpsi_pkg::CFG_PHASE3_STEP, jpsi_pkg::FRAC_ONE);
        write_reg(jpsi_pkg::CFG_PHASE4_STEP, jpsi_pkg::FRAC_ONE);
        write_reg(jpsi_pkg::CFG_P_GAIN, jpsi_pkg::CFG_DATA_W'(pick_gain()));
        repeat (4) send_tick();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_SAMPLE;
        i_joint_index  = '0;
        i_measured_pos = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mismatches     = 0;
        foreach (meas_tab[j]) begin
            meas_tab[j]   = '0;
            start_pose[j] = '0;
        end
        ticks_seen = '0;
        latched    = 1'b0;
        cur_p_gain = jpsi_pkg::P_GAIN_RST;
        cur_d_gain = jpsi_pkg::D_GAIN_RST;
        cur_delay  = jpsi_pkg::START_DELAY_RST;
        for (int p = 0; p < jpsi_pkg::NUM_PHASES; p++) begin
            frac[p]     = '0;
            cur_step[p] = jpsi_pkg::STEP_RST;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_delay_edges();
        test_step_extremes();
        test_random_sequence();
        test_finish_and_hold();
        drain_results();

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* joint_pose_sequence_interpolator.f */
hw/rtl/jpsi_pkg.sv
hw/rtl/jpsi_ctrl.sv
hw/rtl/jpsi_datapath.sv
hw/rtl/joint_pose_sequence_interpolator.sv
tb/testbench.sv
